>>> sv/checksummed_frame_receiver_assert.svh
// Assertion helpers shared by the receiver modules.
// They expect signals named clock and reset in the scope where they are used.
`ifndef CHECKSUMMED_FRAME_RECEIVER_ASSERT_SVH
`define CHECKSUMMED_FRAME_RECEIVER_ASSERT_SVH

// same-cycle implication
`define CFR_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define CFR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> sv/cfr_pkg.sv
package cfr_pkg;

   localparam int CFR_MAX_PAYLOAD = 32;

   localparam logic [7:0] CFR_HEAD_RESET = 8'hA5;
   localparam logic [7:0] CFR_TAIL_RESET = 8'h5A;
   localparam logic [5:0] CFR_LEN_RESET  = 6'd16;

   localparam logic [1:0] CFR_REG_HEAD = 2'd0;
   localparam logic [1:0] CFR_REG_TAIL = 2'd1;
   localparam logic [1:0] CFR_REG_LEN  = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL,
      ST_SCAN,
      ST_DRAIN,
      ST_DECIDE,
      ST_EMIT_RD,
      ST_EMIT_LD
   } cfr_state_type;

   typedef struct packed {
      logic push;
      logic scan_start;
      logic scan_rd;
      logic accept_frame;
      logic reject;
      logic emit_rd;
      logic emit_load;
   } cfr_cmd_type;

   typedef struct packed {
      logic frame_full;
      logic scan_last;
      logic frame_ok;
      logic out_free;
      logic emit_last;
   } cfr_status_type;

endpackage

>>> sv/checksummed_frame_receiver.sv
// channel | dir | handshake               | content
// req     | in  | req_tvalid/req_tready   | tdata[7:0] rx_byte
// rsp     | out | rsp_tvalid/rsp_tready   | tdata payload/index/errors, tlast last_byte
// csr     | in  | csr_valid/csr_ready     | csr_index register, csr_data value
//
// A byte that completes no frame passes through ST_IDLE and ST_EVAL. A byte that
// completes one frame length is checked in ST_SCAN, ST_DRAIN and ST_DECIDE,
// reading the frame back through the single read port of the window RAM; each
// payload byte then goes through ST_EMIT_RD and ST_EMIT_LD. Reset is synchronous
// and active high; no clearing pass. A stalled rsp holds the last payload byte while a new req is taken.
module checksummed_frame_receiver #(
   parameter int MAX_PAYLOAD = cfr_pkg::CFR_MAX_PAYLOAD
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [7:0] payload_byte, [12:8] byte_index, [28:13] error_count
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_data
);

   import cfr_pkg::*;

   cfr_cmd_type    cmd;
   cfr_status_type status;
   logic [7:0]     rsp_payload;
   logic [4:0]     rsp_index;
   logic [15:0]    rsp_errors;

   cfr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   cfr_dpath #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_tdata   (req_tdata),
      .csr_valid   (csr_valid),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_payload (rsp_payload),
      .rsp_index   (rsp_index),
      .rsp_last    (rsp_tlast),
      .rsp_errors  (rsp_errors)
   );

   assign csr_ready = 1'b1;
   assign rsp_tdata = {3'b000, rsp_errors, rsp_index, rsp_payload};

endmodule

>>> sv/cfr_ram.sv
module cfr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/cfr_ctrl.sv
`include "checksummed_frame_receiver_assert.svh"

module cfr_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  cfr_pkg::cfr_status_type status,
   output cfr_pkg::cfr_cmd_type    cmd
);

   import cfr_pkg::*;

   cfr_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.push = 1'b1;
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (status.frame_full) begin
               cmd.scan_start = 1'b1;
               state_in       = ST_SCAN;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_SCAN: begin
            cmd.scan_rd = 1'b1;
            if (status.scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (status.frame_ok) begin
               cmd.accept_frame = 1'b1;
               state_in         = ST_EMIT_RD;
            end else begin
               cmd.reject = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         ST_EMIT_RD: begin
            cmd.emit_rd = 1'b1;
            state_in    = ST_EMIT_LD;
         end
         ST_EMIT_LD: begin
            if (status.out_free) begin
               cmd.emit_load = 1'b1;
               state_in      = status.emit_last ? ST_IDLE : ST_EMIT_RD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   `CFR_ASSERT_NEXT(a_push_to_eval, cmd.push, state_ff == ST_EVAL, "push not followed by eval")
   `CFR_ASSERT_IMPL(a_load_when_free, cmd.emit_load, status.out_free, "load over held result")

endmodule

>>> sv/cfr_dpath.sv
`include "checksummed_frame_receiver_assert.svh"

module cfr_dpath #(
   parameter int MAX_PAYLOAD = cfr_pkg::CFR_MAX_PAYLOAD
) (
   input  logic                    clock,
   input  logic                    reset,
   input  cfr_pkg::cfr_cmd_type    cmd,
   output cfr_pkg::cfr_status_type status,
   input  logic [7:0]              req_tdata,
   input  logic                    csr_valid,
   input  logic [1:0]              csr_index,
   input  logic [7:0]              csr_data,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [7:0]              rsp_payload,
   output logic [4:0]              rsp_index,
   output logic                    rsp_last,
   output logic [15:0]             rsp_errors
);

   import cfr_pkg::*;

   localparam int WIN_DEPTH = MAX_PAYLOAD + 3;
   localparam int AW        = $clog2(WIN_DEPTH);
   localparam int RAM_DEPTH = 1 << AW;
   localparam int FW        = $clog2(MAX_PAYLOAD + 4);
   localparam int PW        = $clog2(MAX_PAYLOAD + 1);

   logic [7:0]    head_cfg_ff, tail_cfg_ff;
   logic [5:0]    len_cfg_ff;
   logic [PW-1:0] plen;
   logic [FW-1:0] flen;
   logic [FW:0]   bsf_inc;

   logic [FW-1:0] bsf_ff, bsf_in;
   logic [AW-1:0] newest_ff, k_ff, tag_k_ff, wr_addr, rd_addr;
   logic          tag_valid_ff;
   logic [7:0]    rd_data, sum_ff, rx_last_ff;
   logic          head_ok_ff, cks_ok_ff;
   logic [PW-1:0] idx_ff;
   logic [15:0]   err_ff;

   logic          rsp_valid_ff;
   logic [7:0]    payload_ff;
   logic [4:0]    index_ff;
   logic          last_ff;
   logic [15:0]   errout_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         head_cfg_ff <= CFR_HEAD_RESET;
         tail_cfg_ff <= CFR_TAIL_RESET;
         len_cfg_ff  <= CFR_LEN_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CFR_REG_HEAD: head_cfg_ff <= csr_data;
            CFR_REG_TAIL: tail_cfg_ff <= csr_data;
            CFR_REG_LEN:  len_cfg_ff  <= csr_data[5:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (len_cfg_ff == 6'd0) begin
         plen = PW'(1);
      end else if (len_cfg_ff > 6'(MAX_PAYLOAD)) begin
         plen = PW'(MAX_PAYLOAD);
      end else begin
         plen = PW'(len_cfg_ff);
      end
   end

   assign flen    = FW'(plen) + FW'(3);
   assign bsf_inc = {1'b0, bsf_ff} + (FW+1)'(1);

   always_comb begin
      bsf_in = bsf_ff;
      if (cmd.push) begin
         bsf_in = (bsf_inc > {1'b0, flen}) ? flen : bsf_inc[FW-1:0];
      end else if (cmd.accept_frame) begin
         bsf_in = '0;
      end else if (cmd.reject) begin
         bsf_in = flen - FW'(1);
      end
   end

   assign wr_addr = newest_ff + AW'(1);
   assign rd_addr = newest_ff - k_ff;

   cfr_ram #(
      .WIDTH (8),
      .DEPTH (RAM_DEPTH)
   ) u_window (
      .clock   (clock),
      .wr_en   (cmd.push),
      .wr_addr (wr_addr),
      .wr_data (req_tdata),
      .rd_en   (cmd.scan_rd || cmd.emit_rd),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         bsf_ff       <= '0;
         newest_ff    <= '0;
         tag_valid_ff <= 1'b0;
         err_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         bsf_ff       <= bsf_in;
         tag_valid_ff <= cmd.scan_rd;
         if (cmd.push) begin
            newest_ff <= wr_addr;
         end
         if (cmd.reject && err_ff != 16'hFFFF) begin
            err_ff <= err_ff + 16'd1;
         end
         if (cmd.emit_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         rx_last_ff <= req_tdata;
      end
      if (cmd.scan_start) begin
         k_ff       <= AW'(flen - FW'(1));
         sum_ff     <= '0;
         head_ok_ff <= 1'b0;
         cks_ok_ff  <= 1'b0;
      end else if (cmd.scan_rd || cmd.emit_load) begin
         k_ff <= k_ff - AW'(1);
      end else if (cmd.accept_frame) begin
         k_ff <= AW'(flen - FW'(2));
      end
      if (cmd.scan_rd) begin
         tag_k_ff <= k_ff;
      end
      if (tag_valid_ff) begin
         if (tag_k_ff == AW'(flen - FW'(1))) begin
            head_ok_ff <= (rd_data == head_cfg_ff);
         end else if (tag_k_ff == AW'(1)) begin
            cks_ok_ff <= (rd_data == sum_ff);
         end else begin
            sum_ff <= sum_ff + rd_data;
         end
      end
      if (cmd.accept_frame) begin
         idx_ff <= '0;
      end else if (cmd.emit_load) begin
         idx_ff <= idx_ff + PW'(1);
      end
      if (cmd.emit_load) begin
         payload_ff <= rd_data;
         index_ff   <= 5'(idx_ff);
         last_ff    <= status.emit_last;
         errout_ff  <= err_ff;
      end
   end

   assign status.frame_full = (bsf_ff == flen);
   assign status.scan_last  = (k_ff == AW'(1));
   assign status.frame_ok   = head_ok_ff && cks_ok_ff && (rx_last_ff == tail_cfg_ff);
   assign status.out_free   = !rsp_valid_ff || rsp_tready;
   assign status.emit_last  = (idx_ff == plen - PW'(1));

   assign rsp_tvalid  = rsp_valid_ff;
   assign rsp_payload = payload_ff;
   assign rsp_index   = index_ff;
   assign rsp_last    = last_ff;
   assign rsp_errors  = errout_ff;

   `CFR_ASSERT_IMPL(a_scan_on_full, cmd.scan_start, bsf_ff == flen, "scan without full frame")
   `CFR_ASSERT_NEXT(a_err_monotonic, 1'b1, err_ff >= $past(err_ff), "error count went down")

endmodule
